[hdl/bhi_pkg.sv]
`default_nettype none
package bhi_pkg;

   localparam int KEY_W = 64;
   localparam int VLEN_W = 16;
   localparam int STATUS_W = 3;
   localparam int SLOT_W = 13;
   localparam int OFFS_W = 20;
   localparam int SLEN_W = 17;
   localparam int MAINS_W = 11;
   localparam int OVF_W = 10;
   localparam int LIMIT_W = 21;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DATA_W = 21;

   localparam logic [MAINS_W-1:0] MAINS_RESET = 11'd1021;
   localparam logic [OVF_W-1:0] OVF_RESET = 10'd3;
   localparam logic [LIMIT_W-1:0] LIMIT_RESET = 21'd1048576;

   localparam logic [CSR_IDX_W-1:0] CSR_MAINS = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_OVF = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_LIMIT = 2'd2;

   localparam logic [STATUS_W-1:0] ST_OK = 3'd0;
   localparam logic [STATUS_W-1:0] ST_DUP = 3'd1;
   localparam logic [STATUS_W-1:0] ST_POOL = 3'd2;
   localparam logic [STATUS_W-1:0] ST_SPACE = 3'd3;
   localparam logic [STATUS_W-1:0] ST_ZERO = 3'd4;

   typedef struct packed {
      logic [KEY_W-1:0] key;
      logic [VLEN_W-1:0] value_length;
   } req_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [SLOT_W-1:0] slot_index;
      logic [OFFS_W-1:0] value_offset;
      logic [SLEN_W-1:0] stored_length;
   } rsp_type;

   typedef struct packed {
      logic [KEY_W-1:0] key;
      logic [SLEN_W-1:0] need;
      logic zero_key;
   } job_type;

   typedef enum logic [1:0] {
      FR_IDLE,
      FR_DIV,
      FR_PUSH
   } front_state_type;

   typedef enum logic [2:0] {
      BK_IDLE,
      BK_READ,
      BK_CHECK,
      BK_SPACE,
      BK_COMMIT,
      BK_CLEAR
   } back_state_type;

endpackage
`default_nettype wire

[hdl/bhi_front.sv]
`default_nettype none
module bhi_front
   import bhi_pkg::*;
   #(
      parameter int TOTAL_BUCKETS = 1024,
      parameter int BUCKET_W = 10
   )
   (
      input wire logic clock,
      input wire logic reset,
      input wire logic start,
      input req_type req_item,
      input wire logic [MAINS_W-1:0] mains,
      output logic idle,
      output logic push,
      output job_type push_job,
      output logic [BUCKET_W-1:0] push_bucket,
      input wire logic push_ready
   );

   // Restoring division of the key by the bucket count, one quotient bit a cycle.
   front_state_type state_ff, state_in;
   logic [KEY_W-1:0] key_ff, key_in;
   logic [SLEN_W-1:0] need_ff, need_in;
   logic zero_ff, zero_in;
   logic [MAINS_W:0] rem_ff, rem_in;
   logic [6:0] cnt_ff, cnt_in;
   logic [KEY_W-1:0] shift_ff, shift_in;
   logic [MAINS_W:0] trial;
   logic [MAINS_W-1:0] divisor;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= FR_IDLE;
      end else begin
         state_ff <= state_in;
      end
      key_ff <= key_in;
      need_ff <= need_in;
      zero_ff <= zero_in;
      rem_ff <= rem_in;
      cnt_ff <= cnt_in;
      shift_ff <= shift_in;
   end

   always_comb begin
      divisor = mains;
      if (mains == '0) begin
         divisor = MAINS_W'(1);
      end else if (int'(mains) > TOTAL_BUCKETS) begin
         divisor = MAINS_W'(TOTAL_BUCKETS);
      end
      state_in = state_ff;
      key_in = key_ff;
      need_in = need_ff;
      zero_in = zero_ff;
      rem_in = rem_ff;
      cnt_in = cnt_ff;
      shift_in = shift_ff;
      trial = {rem_ff[MAINS_W-1:0], shift_ff[KEY_W-1]};
      idle = 1'b0;
      push = 1'b0;
      case (state_ff)
         FR_IDLE: begin
            idle = 1'b1;
            if (start) begin
               key_in = req_item.key;
               shift_in = req_item.key;
               need_in = {1'b0, req_item.value_length} + 17'd1;
               zero_in = (req_item.key == '0);
               rem_in = '0;
               cnt_in = 7'd0;
               state_in = (req_item.key == '0) ? FR_PUSH : FR_DIV;
            end
         end
         FR_DIV: begin
            if (trial >= {1'b0, divisor}) begin
               rem_in = trial - {1'b0, divisor};
            end else begin
               rem_in = trial;
            end
            shift_in = {shift_ff[KEY_W-2:0], 1'b0};
            cnt_in = cnt_ff + 7'd1;
            if (cnt_ff == 7'd63) begin
               state_in = FR_PUSH;
            end
         end
         FR_PUSH: begin
            push = 1'b1;
            if (push_ready) begin
               state_in = FR_IDLE;
            end
         end
         default: state_in = FR_IDLE;
      endcase
   end

   assign push_job = '{key: key_ff, need: need_ff, zero_key: zero_ff};
   assign push_bucket = zero_ff ? '0 : BUCKET_W'(rem_ff);

endmodule
`default_nettype wire

[hdl/bhi_queue.sv]
`default_nettype none
module bhi_queue
   import bhi_pkg::*;
   #(
      parameter int BUCKET_W = 10
   )
   (
      input wire logic clock,
      input wire logic reset,
      input wire logic push,
      input job_type push_job,
      input wire logic [BUCKET_W-1:0] push_bucket,
      output logic push_ready,
      input wire logic pop,
      output logic pop_valid,
      output job_type pop_job,
      output logic [BUCKET_W-1:0] pop_bucket
   );

   // Two-entry queue.
   job_type job_ff [2];
   logic [BUCKET_W-1:0] bkt_ff [2];
   logic [1:0] count_ff, count_in;
   logic rd_ff, rd_in, wr_ff, wr_in;

   assign push_ready = (count_ff != 2'd2);
   assign pop_valid = (count_ff != 2'd0);
   assign pop_job = job_ff[rd_ff];
   assign pop_bucket = bkt_ff[rd_ff];

   always_comb begin
      count_in = count_ff;
      rd_in = rd_ff;
      wr_in = wr_ff;
      if (push && push_ready) begin
         wr_in = ~wr_ff;
         count_in = count_in + 2'd1;
      end
      if (pop && pop_valid) begin
         rd_in = ~rd_ff;
         count_in = count_in - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         rd_ff <= 1'b0;
         wr_ff <= 1'b0;
      end else begin
         count_ff <= count_in;
         rd_ff <= rd_in;
         wr_ff <= wr_in;
      end
      if (push && push_ready) begin
         job_ff[wr_ff] <= push_job;
         bkt_ff[wr_ff] <= push_bucket;
      end
   end

endmodule
`default_nettype wire

[hdl/bhi_back.sv]
`default_nettype none
module bhi_back
   import bhi_pkg::*;
   #(
      parameter int WAYS = 8,
      parameter int TOTAL_BUCKETS = 1024,
      parameter int ENTRY_SPACE = 1048576,
      parameter int BUCKET_W = 10
   )
   (
      input wire logic clock,
      input wire logic reset,
      input wire logic pop_valid,
      input job_type pop_job,
      input wire logic [BUCKET_W-1:0] pop_bucket,
      output logic pop,
      input wire logic [MAINS_W-1:0] mains,
      input wire logic [OVF_W-1:0] ovf_count,
      input wire logic [LIMIT_W-1:0] limit_cfg,
      output logic rsp_valid_in,
      output rsp_type rsp_in
   );

   localparam int WAY_W = (WAYS > 1) ? $clog2(WAYS) : 1;
   localparam int SLOTS = TOTAL_BUCKETS * WAYS;
   localparam int ADDR_W = $clog2(SLOTS);
   localparam int VISIT_W = $clog2(TOTAL_BUCKETS + 1);
   localparam int FILL_W = $clog2(ENTRY_SPACE + 1) > LIMIT_W ? $clog2(ENTRY_SPACE + 1) : LIMIT_W;
   localparam int PTR_W = 64;

   logic [KEY_W-1:0] key_mem [SLOTS];
   logic [PTR_W-1:0] ptr_mem [SLOTS];
   logic [KEY_W-1:0] rdata_ff;

   back_state_type state_ff, state_in;
   logic [ADDR_W-1:0] clr_ff, clr_in;
   logic [BUCKET_W-1:0] bucket_ff, bucket_in;
   logic [WAY_W-1:0] way_ff, way_in;
   logic [VISIT_W-1:0] visits_ff, visits_in;
   logic [OVF_W-1:0] used_ff, used_in;
   logic [LIMIT_W-1:0] fill_ff, fill_in;
   logic [ADDR_W-1:0] slot_ff, slot_in, link_ff, link_in;
   logic alloc_ff, alloc_in;
   logic [BUCKET_W-1:0] fresh_ff, fresh_in;
   job_type job_ff, job_in;

   logic [ADDR_W-1:0] raddr;
   logic we;
   logic [ADDR_W-1:0] waddr;
   logic [KEY_W-1:0] wdata;
   logic pwe;
   logic [MAINS_W:0] mains_eff;
   logic [MAINS_W+OVF_W:0] fresh_full;
   logic [FILL_W:0] limit_eff, end_sum;

   always_comb begin
      mains_eff = {1'b0, mains};
      if (mains == '0) begin
         mains_eff = (MAINS_W+1)'(1);
      end else if (int'(mains) > TOTAL_BUCKETS) begin
         mains_eff = (MAINS_W+1)'(TOTAL_BUCKETS);
      end
      fresh_full = (MAINS_W+OVF_W+1)'(mains_eff) + (MAINS_W+OVF_W+1)'(used_ff);
      limit_eff = (FILL_W+1)'(limit_cfg);
      if (limit_eff > (FILL_W+1)'(ENTRY_SPACE)) begin
         limit_eff = (FILL_W+1)'(ENTRY_SPACE);
      end
      end_sum = (FILL_W+1)'(fill_ff) + (FILL_W+1)'(job_ff.need);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= BK_CLEAR;
         clr_ff <= '0;
         used_ff <= '0;
         fill_ff <= '0;
      end else begin
         state_ff <= state_in;
         clr_ff <= clr_in;
         used_ff <= used_in;
         fill_ff <= fill_in;
      end
      bucket_ff <= bucket_in;
      way_ff <= way_in;
      visits_ff <= visits_in;
      slot_ff <= slot_in;
      link_ff <= link_in;
      alloc_ff <= alloc_in;
      fresh_ff <= fresh_in;
      job_ff <= job_in;
      rdata_ff <= key_mem[raddr];
      if (we) begin
         key_mem[waddr] <= wdata;
      end
      if (pwe) begin
         ptr_mem[slot_ff] <= {15'd0, job_ff.need, 12'd0, 20'(fill_ff)};
      end
   end

   always_comb begin
      state_in = state_ff;
      clr_in = clr_ff;
      used_in = used_ff;
      fill_in = fill_ff;
      bucket_in = bucket_ff;
      way_in = way_ff;
      visits_in = visits_ff;
      slot_in = slot_ff;
      link_in = link_ff;
      alloc_in = alloc_ff;
      fresh_in = fresh_ff;
      job_in = job_ff;
      raddr = ADDR_W'(bucket_ff) * ADDR_W'(WAYS) + ADDR_W'(way_ff);
      we = 1'b0;
      waddr = slot_ff;
      wdata = job_ff.key;
      pwe = 1'b0;
      pop = 1'b0;
      rsp_valid_in = 1'b0;
      rsp_in = '{status: ST_OK, slot_index: '0, value_offset: '0,
                 stored_length: job_ff.need};
      case (state_ff)
         BK_CLEAR: begin
            we = 1'b1;
            waddr = clr_ff;
            wdata = '0;
            clr_in = clr_ff + 1'b1;
            if (clr_ff == ADDR_W'(SLOTS - 1)) begin
               state_in = BK_IDLE;
            end
         end
         BK_IDLE: begin
            if (pop_valid) begin
               pop = 1'b1;
               job_in = pop_job;
               bucket_in = pop_bucket;
               way_in = '0;
               visits_in = '0;
               alloc_in = 1'b0;
               if (pop_job.zero_key) begin
                  rsp_valid_in = 1'b1;
                  rsp_in = '{status: ST_ZERO, slot_index: '0, value_offset: '0,
                             stored_length: pop_job.need};
               end else begin
                  state_in = BK_READ;
               end
            end
         end
         BK_READ: begin
            state_in = BK_CHECK;
         end
         BK_CHECK: begin
            if (way_ff != WAY_W'(WAYS - 1)) begin
               if (rdata_ff == job_ff.key) begin
                  rsp_valid_in = 1'b1;
                  rsp_in.status = ST_DUP;
                  state_in = BK_IDLE;
               end else if (rdata_ff == '0) begin
                  slot_in = raddr;
                  state_in = BK_SPACE;
               end else begin
                  way_in = way_ff + 1'b1;
                  state_in = BK_READ;
               end
            end else if (rdata_ff != '0) begin
               if (rdata_ff >= KEY_W'(TOTAL_BUCKETS)
                   || visits_ff == VISIT_W'(TOTAL_BUCKETS - 1)) begin
                  rsp_valid_in = 1'b1;
                  rsp_in.status = ST_POOL;
                  state_in = BK_IDLE;
               end else begin
                  bucket_in = rdata_ff[BUCKET_W-1:0];
                  way_in = '0;
                  visits_in = visits_ff + 1'b1;
                  state_in = BK_READ;
               end
            end else begin
               link_in = raddr;
               if (used_ff >= ovf_count
                   || fresh_full >= (MAINS_W+OVF_W+1)'(TOTAL_BUCKETS)) begin
                  rsp_valid_in = 1'b1;
                  rsp_in.status = ST_POOL;
                  state_in = BK_IDLE;
               end else begin
                  alloc_in = 1'b1;
                  fresh_in = fresh_full[BUCKET_W-1:0];
                  slot_in = ADDR_W'(fresh_full[BUCKET_W-1:0]) * ADDR_W'(WAYS);
                  state_in = BK_SPACE;
               end
            end
         end
         BK_SPACE: begin
            if (end_sum >= limit_eff) begin
               rsp_valid_in = 1'b1;
               rsp_in.status = ST_SPACE;
               state_in = BK_IDLE;
            end else begin
               we = 1'b1;
               pwe = 1'b1;
               rsp_valid_in = 1'b1;
               rsp_in.slot_index = SLOT_W'(slot_ff);
               rsp_in.value_offset = fill_ff[OFFS_W-1:0];
               fill_in = end_sum[LIMIT_W-1:0];
               state_in = alloc_ff ? BK_COMMIT : BK_IDLE;
            end
         end
         BK_COMMIT: begin
            we = 1'b1;
            waddr = link_ff;
            wdata = KEY_W'(fresh_ff);
            used_in = used_ff + 1'b1;
            state_in = BK_IDLE;
         end
         default: state_in = BK_IDLE;
      endcase
   end

endmodule
`default_nettype wire

[hdl/bucketed_hash_insert_with_alloc.sv]
// Channel   Ports                                    Handshake
// request   start, busy, req_item                    start && !busy
// result    rsp_valid, rsp_item                      one-cycle strobe
// config    csr_valid, csr_ready, csr_index, csr_data csr_valid && csr_ready
// After reset the key store is swept clear, one slot a cycle, all TOTAL_BUCKETS*WAYS slots.
// The front takes an item, divides the key by the bucket count and pushes the key with
// the remainder as its bucket; a zero key skips the division. The back pops a job, passes
// each slot read along the chain through BK_READ and BK_CHECK, checks space and stores in
// BK_SPACE and links a fresh bucket in BK_COMMIT; the result is registered, never stalled.
// busy is high while the front divides or pushes, including any wait for room in the two-entry queue.
`default_nettype none
module bucketed_hash_insert_with_alloc
   import bhi_pkg::*;
   #(
      parameter int WAYS = 8,
      parameter int TOTAL_BUCKETS = 1024,
      parameter int ENTRY_SPACE = 1048576
   )
   (
      input wire logic clock,
      input wire logic reset,
      input wire logic start,
      output logic busy,
      input req_type req_item,
      output logic rsp_valid,
      output rsp_type rsp_item,
      input wire logic csr_valid,
      output logic csr_ready,
      input wire logic [CSR_IDX_W-1:0] csr_index,
      input wire logic [CSR_DATA_W-1:0] csr_data
   );

   localparam int BUCKET_W = $clog2(TOTAL_BUCKETS);

   logic [MAINS_W-1:0] mains_ff;
   logic [OVF_W-1:0] ovf_ff;
   logic [LIMIT_W-1:0] limit_ff;
   logic front_idle, push, push_ready, pop, pop_valid;
   job_type push_job, pop_job;
   logic [BUCKET_W-1:0] push_bucket, pop_bucket;
   logic rsp_valid_in, rsp_valid_ff;
   rsp_type rsp_in, rsp_ff;

   assign csr_ready = 1'b1;
   assign busy = !front_idle;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_item = rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         mains_ff <= MAINS_RESET;
         ovf_ff <= OVF_RESET;
         limit_ff <= LIMIT_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid) begin
            case (csr_index)
               CSR_MAINS: mains_ff <= csr_data[MAINS_W-1:0];
               CSR_OVF: ovf_ff <= csr_data[OVF_W-1:0];
               CSR_LIMIT: limit_ff <= csr_data;
               default: ;
            endcase
         end
      end
      rsp_ff <= rsp_in;
   end

   bhi_front #(.TOTAL_BUCKETS(TOTAL_BUCKETS), .BUCKET_W(BUCKET_W)) u_front (
      .clock(clock), .reset(reset), .start(start), .req_item(req_item),
      .mains(mains_ff), .idle(front_idle), .push(push), .push_job(push_job),
      .push_bucket(push_bucket), .push_ready(push_ready)
   );

   bhi_queue #(.BUCKET_W(BUCKET_W)) u_queue (
      .clock(clock), .reset(reset), .push(push), .push_job(push_job),
      .push_bucket(push_bucket), .push_ready(push_ready), .pop(pop),
      .pop_valid(pop_valid), .pop_job(pop_job), .pop_bucket(pop_bucket)
   );

   bhi_back #(
      .WAYS(WAYS), .TOTAL_BUCKETS(TOTAL_BUCKETS), .ENTRY_SPACE(ENTRY_SPACE),
      .BUCKET_W(BUCKET_W)
   ) u_back (
      .clock(clock), .reset(reset), .pop_valid(pop_valid), .pop_job(pop_job),
      .pop_bucket(pop_bucket), .pop(pop), .mains(mains_ff), .ovf_count(ovf_ff),
      .limit_cfg(limit_ff), .rsp_valid_in(rsp_valid_in), .rsp_in(rsp_in)
   );

endmodule
`default_nettype wire
